@@ sv/ipv6_tse_pkg.sv @@
// Shared types, protocol codes and parse phase codes for the IPv6 traffic
// selector extractor. No dependencies.
`default_nettype none

package ipv6_tse_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    // header-relative counter and header length widths (longest header 2048 bytes)
    localparam int REL_W = 11;
    localparam int LEN_W = 12;

    // result queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // parse phases
    localparam logic [2:0] PH_OUTER  = 3'd0;
    localparam logic [2:0] PH_NESTED = 3'd1;
    localparam logic [2:0] PH_EXT    = 3'd2;
    localparam logic [2:0] PH_FRAG   = 3'd3;
    localparam logic [2:0] PH_PORTS  = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // protocol numbers
    localparam logic [7:0] PROTO_HOPOPT = 8'd0;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_IPV6   = 8'd41;
    localparam logic [7:0] PROTO_ROUTE  = 8'd43;
    localparam logic [7:0] PROTO_FRAG   = 8'd44;
    localparam logic [7:0] PROTO_DSTOPT = 8'd60;
    localparam logic [7:0] PROTO_MOBIL  = 8'd135;
    localparam logic [7:0] PROTO_NONE   = 8'd255;

    localparam logic [LEN_W-1:0] LEN_IPV6  = 12'd40;
    localparam logic [LEN_W-1:0] LEN_EXT   = 12'd8;
    localparam logic [LEN_W-1:0] LEN_PORTS = 12'd4;

    typedef struct packed {
        logic [2:0]       phase;
        logic [LEN_W-1:0] len;
    } t_hdr_class;

    // parser state captured at the last byte of a packet
    typedef struct packed {
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [63:0] dst_high;
        logic [63:0] dst_low;
        logic [2:0]  phase;
        logic [7:0]  proto;
        logic [31:0] port_pair;
    } t_snap;

    function automatic t_hdr_class classify(input logic [7:0] proto);
        t_hdr_class c;
        c = '0;
        unique case (proto)
            PROTO_IPV6: begin
                c.phase = PH_NESTED;
                c.len   = LEN_IPV6;
            end
            PROTO_HOPOPT, PROTO_ROUTE, PROTO_DSTOPT, PROTO_MOBIL: begin
                c.phase = PH_EXT;
                c.len   = LEN_EXT;
            end
            PROTO_FRAG: begin
                c.phase = PH_FRAG;
                c.len   = LEN_EXT;
            end
            PROTO_TCP, PROTO_UDP: begin
                c.phase = PH_PORTS;
                c.len   = LEN_PORTS;
            end
            default: begin
                c.phase = PH_DONE;
                c.len   = '0;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/ipv6_tse_front.sv @@
// Byte parser: walks the IPv6 header chain one byte per transfer and pushes
// a state snapshot on the last byte. Depends on ipv6_tse_pkg.
`default_nettype none

module ipv6_tse_front #(
    parameter int OFFSET_BITS = ipv6_tse_pkg::OFFSET_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire [7:0]           i_byte,
    input  wire                 i_last,
    input  wire                 i_q_full,
    output logic                o_push,
    output ipv6_tse_pkg::t_snap o_snap
);
    import ipv6_tse_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    logic [OFFSET_BITS-1:0] r_pos,   n_pos;
    logic [REL_W-1:0]       r_rel,   n_rel;
    logic [LEN_W-1:0]       r_len,   n_len;
    logic [2:0]             r_phase, n_phase;
    logic [7:0]             r_proto, n_proto;
    logic [7:0]             r_pend,  n_pend;
    logic [63:0]            r_src_h, n_src_h;
    logic [63:0]            r_src_l, n_src_l;
    logic [63:0]            r_dst_h, n_dst_h;
    logic [63:0]            r_dst_l, n_dst_l;
    logic [31:0]            r_pp,    n_pp;

    logic       accept;
    logic       parse_en;
    t_hdr_class cls;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign parse_en = (r_phase != PH_DONE) && (r_pos != POS_MAX);
    assign o_push   = accept && i_last;

    always_comb begin
        n_pos   = r_pos;
        n_rel   = r_rel;
        n_len   = r_len;
        n_phase = r_phase;
        n_proto = r_proto;
        n_pend  = r_pend;
        n_src_h = r_src_h;
        n_src_l = r_src_l;
        n_dst_h = r_dst_h;
        n_dst_l = r_dst_l;
        n_pp    = r_pp;
        cls     = '0;
        if (accept) begin
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
            if (parse_en) begin
                unique case (r_phase)
                    PH_OUTER: begin
                        if (r_rel == 11'd6) begin
                            n_pend = i_byte;
                        end else begin
                            unique case (r_rel[REL_W-1:3])
                                8'd1:    n_src_h = {r_src_h[55:0], i_byte};
                                8'd2:    n_src_l = {r_src_l[55:0], i_byte};
                                8'd3:    n_dst_h = {r_dst_h[55:0], i_byte};
                                8'd4:    n_dst_l = {r_dst_l[55:0], i_byte};
                                default: ;
                            endcase
                        end
                    end
                    PH_NESTED: begin
                        if (r_rel == 11'd6) begin
                            n_pend = i_byte;
                        end
                    end
                    PH_EXT: begin
                        if (r_rel == 11'd0) begin
                            n_pend = i_byte;
                        end else if (r_rel == 11'd1) begin
                            n_len = {({1'b0, i_byte} + 9'd1), 3'b000};
                        end
                    end
                    PH_FRAG: begin
                        if (r_rel == 11'd0) begin
                            n_pend = i_byte;
                        end
                    end
                    PH_PORTS: n_pp = {r_pp[23:0], i_byte};
                    default: ;
                endcase
                if (({1'b0, r_rel} + 12'd1) == n_len) begin
                    if (r_phase == PH_PORTS) begin
                        n_phase = PH_DONE;
                    end else begin
                        cls     = classify(n_pend);
                        n_proto = n_pend;
                        n_phase = cls.phase;
                        n_len   = cls.len;
                        n_rel   = '0;
                    end
                end else begin
                    n_rel = r_rel + 1'b1;
                end
            end
        end

        o_snap.src_high  = n_src_h;
        o_snap.src_low   = n_src_l;
        o_snap.dst_high  = n_dst_h;
        o_snap.dst_low   = n_dst_l;
        o_snap.phase     = n_phase;
        o_snap.proto     = n_proto;
        o_snap.port_pair = n_pp;

        // next packet starts from the outer header again
        if (o_push) begin
            n_pos   = '0;
            n_rel   = '0;
            n_len   = LEN_IPV6;
            n_phase = PH_OUTER;
            n_proto = PROTO_IPV6;
            n_pend  = '0;
            n_src_h = '0;
            n_src_l = '0;
            n_dst_h = '0;
            n_dst_l = '0;
            n_pp    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_rel   <= '0;
            r_len   <= LEN_IPV6;
            r_phase <= PH_OUTER;
            r_proto <= PROTO_IPV6;
            r_pend  <= '0;
            r_src_h <= '0;
            r_src_l <= '0;
            r_dst_h <= '0;
            r_dst_l <= '0;
            r_pp    <= '0;
        end else begin
            r_pos   <= n_pos;
            r_rel   <= n_rel;
            r_len   <= n_len;
            r_phase <= n_phase;
            r_proto <= n_proto;
            r_pend  <= n_pend;
            r_src_h <= n_src_h;
            r_src_l <= n_src_l;
            r_dst_h <= n_dst_h;
            r_dst_l <= n_dst_l;
            r_pp    <= n_pp;
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_phase == PH_OUTER) && (r_pos == '0) && (r_rel == '0))
        else $error("parser not restarted after last byte");

    a_rel_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DONE) |-> ({1'b0, r_rel} < r_len))
        else $error("header offset beyond header length");

endmodule

`default_nettype wire

@@ sv/ipv6_tse_queue.sv @@
// Short result queue between parser and output stage.
// Depends on ipv6_tse_pkg.
`default_nettype none

module ipv6_tse_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  ipv6_tse_pkg::t_snap i_data,
    input  wire                 i_pop,
    output ipv6_tse_pkg::t_snap o_data,
    output logic                o_empty,
    output logic                o_full
);
    import ipv6_tse_pkg::*;

    t_snap              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ sv/ipv6_tse_back.sv @@
// Output stage: turns a parser snapshot into result fields and holds them
// in the output register. Depends on ipv6_tse_pkg.
`default_nettype none

module ipv6_tse_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_empty,
    input  ipv6_tse_pkg::t_snap i_snap,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [295:0]        o_data,
    output logic [1:0]          o_user
);
    import ipv6_tse_pkg::*;

    logic        r_valid;
    logic [63:0] r_src_h, r_src_l, r_dst_h, r_dst_l;
    logic [7:0]  r_proto;
    logic [15:0] r_sport, r_dport;
    logic        r_pv, r_status;

    logic done, ports;

    assign done  = (i_snap.phase == PH_DONE);
    assign ports = done && ((i_snap.proto == PROTO_TCP) || (i_snap.proto == PROTO_UDP));
    assign o_pop = !i_q_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_src_h  <= i_snap.src_high;
            r_src_l  <= i_snap.src_low;
            r_dst_h  <= i_snap.dst_high;
            r_dst_l  <= i_snap.dst_low;
            r_proto  <= (done || (i_snap.phase == PH_PORTS)) ? i_snap.proto : PROTO_NONE;
            r_pv     <= ports;
            r_sport  <= ports ? i_snap.port_pair[31:16] : 16'd0;
            r_dport  <= ports ? i_snap.port_pair[15:0] : 16'd0;
            r_status <= !done;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_dport, r_sport, r_proto, r_dst_l, r_dst_h, r_src_l, r_src_h};
    assign o_user  = {r_status, r_pv};

    a_ports_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_pv) |-> !r_status)
        else $error("ports valid on truncated packet");

    a_ports_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_pv) |-> ((r_sport == 16'd0) && (r_dport == 16'd0)))
        else $error("ports not cleared");

endmodule

`default_nettype wire

@@ sv/ipv6_traffic_selector_extract.sv @@
// IPv6 traffic selector extractor, top level: parser, result queue, output stage.
// Throughput: one packet byte per cycle, no bubbles; the parser is stalled only
// when the two-entry result queue is full.
// The last-byte snapshot is queued, then loaded into the valid output register.
// Reset: synchronous, active low; clears the parser to the outer header, empties
// the queue and drops the output valid. Depends on ipv6_tse_pkg.
`default_nettype none

module ipv6_traffic_selector_extract #(
    parameter int OFFSET_BITS = ipv6_tse_pkg::OFFSET_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // data_byte
    input  wire          s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // src_addr_high, src_addr_low, dst_addr_high, dst_addr_low, payload_protocol,
    // source_port, destination_port
    output logic [295:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser    // ports_valid, status
);
    import ipv6_tse_pkg::*;

    t_snap front_snap, q_snap;
    logic  push, pop, q_empty, q_full;

    ipv6_tse_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_q_full(q_full),
        .o_push  (push),
        .o_snap  (front_snap)
    );

    ipv6_tse_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_snap),
        .i_pop  (pop),
        .o_data (q_snap),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    ipv6_tse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_snap   (q_snap),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_user   (m_axis_tuser)
    );

endmodule

`default_nettype wire
